// File: rtl/hid_keyboard_report_to_char_macros.svh
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_char_macros.svh
// Assertion macros used by the keyboard report decoder.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_TO_CHAR_MACROS_SVH
`define HID_KEYBOARD_REPORT_TO_CHAR_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of i_clk outside reset.
`define HKR_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hkr assertion failed");

// Checked on every rising edge of i_clk, reset included.
`define HKR_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("hkr assertion failed");

`else

`define HKR_ASSERT(label, prop)
`define HKR_ASSERT_ALWAYS(label, prop)

`endif

`endif

// File: rtl/hkr_pkg.sv
// ----------------------------------------------------------------------------
// hkr_pkg
// Types, constants and keymap tables for the keyboard report decoder.
// ----------------------------------------------------------------------------
package hkr_pkg;

    // Number of keycode slots in one boot report.
    localparam int KEY_SLOTS   = 6;
    // Keycodes at or above this value translate to zero.
    localparam int MAP_ENTRIES = 104;

    // Cursor codes produced by the plain table, remapped when control is up.
    localparam logic [7:0] ARROW_RIGHT = 8'h1c;
    localparam logic [7:0] ARROW_LEFT  = 8'h1d;
    localparam logic [7:0] ARROW_UP    = 8'h1e;
    localparam logic [7:0] ARROW_DOWN  = 8'h1f;

    // Control codes the arrows turn into.
    localparam logic [7:0] CTL_B = 8'h02;
    localparam logic [7:0] CTL_F = 8'h06;
    localparam logic [7:0] CTL_N = 8'h0e;
    localparam logic [7:0] CTL_P = 8'h10;

    // Upper-case letters accepted with control held.
    localparam logic [7:0] CHR_A = 8'h41;
    localparam logic [7:0] CHR_B = 8'h42;
    localparam logic [7:0] CHR_C = 8'h43;
    localparam logic [7:0] CHR_D = 8'h44;
    localparam logic [7:0] CHR_E = 8'h45;
    localparam logic [7:0] CHR_F = 8'h46;
    localparam logic [7:0] CHR_K = 8'h4b;
    localparam logic [7:0] CHR_N = 8'h4e;
    localparam logic [7:0] CHR_P = 8'h50;
    localparam logic [7:0] CHR_U = 8'h55;
    // Subtracting this from an upper-case letter gives its control code.
    localparam logic [7:0] CTL_OFFSET = 8'h40;

    typedef logic [7:0] t_code;
    typedef t_code [KEY_SLOTS-1:0] t_code_vec;

    // What one lane finds for its slot.
    typedef struct packed {
        logic  fresh;
        t_code char_code;
    } t_lane_hit;

    typedef t_lane_hit [KEY_SLOTS-1:0] t_hit_vec;

    // One result transaction.
    typedef struct packed {
        logic  char_valid;
        t_code char_code;
    } t_result;

    // US keymap without shift.
    function automatic t_code map_plain(input t_code code);
        t_code c;
        c = 8'h00;
        if (code >= 8'd4 && code <= 8'd29) begin
            c = code + 8'd93;
        end else if (code >= 8'd30 && code <= 8'd38) begin
            c = code + 8'd19;
        end else if (code >= 8'd89 && code <= 8'd97) begin
            c = code - 8'd40;
        end else begin
            case (code)
                8'd1:    c = 8'h01;
                8'd2:    c = 8'h02;
                8'd3:    c = 8'h03;
                8'd39:   c = 8'h30;
                8'd40:   c = 8'h0d;
                8'd41:   c = 8'h1b;
                8'd42:   c = 8'h08;
                8'd43:   c = 8'h09;
                8'd44:   c = 8'h20;
                8'd45:   c = 8'h2d;
                8'd46:   c = 8'h3d;
                8'd47:   c = 8'h5b;
                8'd48:   c = 8'h5d;
                8'd49:   c = 8'h5c;
                8'd51:   c = 8'h3b;
                8'd52:   c = 8'h27;
                8'd53:   c = 8'h60;
                8'd54:   c = 8'h2c;
                8'd55:   c = 8'h2e;
                8'd56:   c = 8'h2f;
                8'd73:   c = 8'h12;
                8'd76:   c = 8'h7f;
                8'd79:   c = ARROW_RIGHT;
                8'd80:   c = ARROW_LEFT;
                8'd81:   c = ARROW_DOWN;
                8'd82:   c = ARROW_UP;
                8'd84:   c = 8'h2f;
                8'd85:   c = 8'h2a;
                8'd86:   c = 8'h2d;
                8'd87:   c = 8'h2b;
                8'd88:   c = 8'h0d;
                8'd98:   c = 8'h30;
                8'd99:   c = 8'h2e;
                8'd100:  c = 8'h5c;
                8'd103:  c = 8'h3d;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    // US keymap with shift.
    function automatic t_code map_shifted(input t_code code);
        t_code c;
        c = 8'h00;
        if (code >= 8'd4 && code <= 8'd29) begin
            c = code + 8'd61;
        end else if (code >= 8'd89 && code <= 8'd97) begin
            c = code - 8'd40;
        end else begin
            case (code)
                8'd30:   c = 8'h21;
                8'd31:   c = 8'h40;
                8'd32:   c = 8'h23;
                8'd33:   c = 8'h24;
                8'd34:   c = 8'h25;
                8'd35:   c = 8'h5e;
                8'd36:   c = 8'h26;
                8'd37:   c = 8'h2a;
                8'd38:   c = 8'h28;
                8'd39:   c = 8'h29;
                8'd40:   c = 8'h0a;
                8'd41:   c = 8'h1b;
                8'd42:   c = 8'h08;
                8'd43:   c = 8'h09;
                8'd44:   c = 8'h20;
                8'd45:   c = 8'h5f;
                8'd46:   c = 8'h2b;
                8'd47:   c = 8'h7b;
                8'd48:   c = 8'h7d;
                8'd49:   c = 8'h7c;
                8'd50:   c = 8'h7e;
                8'd51:   c = 8'h3a;
                8'd52:   c = 8'h22;
                8'd53:   c = 8'h7e;
                8'd54:   c = 8'h3c;
                8'd55:   c = 8'h3e;
                8'd56:   c = 8'h3f;
                8'd84:   c = 8'h2f;
                8'd85:   c = 8'h2a;
                8'd86:   c = 8'h2d;
                8'd87:   c = 8'h2b;
                8'd88:   c = 8'h0a;
                8'd98:   c = 8'h30;
                8'd99:   c = 8'h2e;
                8'd100:  c = 8'h7c;
                8'd103:  c = 8'h3d;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    // Table lookup with the out-of-range guard.
    function automatic t_code lookup(input t_code code, input logic shifted);
        t_code c;
        c = 8'h00;
        if (code < 8'(MAP_ENTRIES)) begin
            c = shifted ? map_shifted(code) : map_plain(code);
        end
        return c;
    endfunction

endpackage

// File: rtl/hid_keyboard_report_to_char.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_char
// Turns boot keyboard reports into characters of newly pressed keys.
// ----------------------------------------------------------------------------
// Input channel: one report per transaction (six keycodes, control and shift
// flags), taken at a rising edge with i_valid high and o_stall low.
// Output channel: one result per report (o_char_valid, o_char_code), taken
// at a rising edge with o_valid high and i_stall low. A report without a new
// key still yields a result, with o_char_valid and o_char_code at zero.
// A result is registered in the output or skid register. Throughput: one
// report per cycle while o_stall is low; six lanes test and translate all
// slots in the same cycle, and the previous-report register is updated at
// accept. A two-entry output buffer (output register plus skid register)
// lets the block take a report while a result waits. When the receiver
// stalls, the skid register fills and o_stall rises until the receiver takes
// a result. Reset (synchronous, active low) clears the stored previous
// keycodes to zero and empties the output buffer.
// ----------------------------------------------------------------------------
`include "hid_keyboard_report_to_char_macros.svh"

module hid_keyboard_report_to_char (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  hkr_pkg::t_code i_slot0_code,
    input  hkr_pkg::t_code i_slot1_code,
    input  hkr_pkg::t_code i_slot2_code,
    input  hkr_pkg::t_code i_slot3_code,
    input  hkr_pkg::t_code i_slot4_code,
    input  hkr_pkg::t_code i_slot5_code,
    input  logic           i_ctrl_held,
    input  logic           i_shift_held,
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_char_valid,
    output hkr_pkg::t_code o_char_code
);
    import hkr_pkg::*;

    t_code_vec new_codes;
    t_code_vec r_prev;
    t_hit_vec  hits;
    t_result   merged;
    t_result   r_out;
    t_result   r_skid;
    logic      r_out_valid;
    logic      r_skid_valid;
    logic      in_accept;
    logic      out_free;

    assign new_codes[0] = i_slot0_code;
    assign new_codes[1] = i_slot1_code;
    assign new_codes[2] = i_slot2_code;
    assign new_codes[3] = i_slot3_code;
    assign new_codes[4] = i_slot4_code;
    assign new_codes[5] = i_slot5_code;

    // One lane per slot; earlier slots compare against this report's codes.
    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
        t_code_vec compare;

        always_comb begin
            for (int j = 0; j < KEY_SLOTS; j++) begin
                compare[j] = (j < g) ? new_codes[j] : r_prev[j];
            end
        end

        hkr_lane u_lane (
            .i_code       (new_codes[g]),
            .i_compare    (compare),
            .i_ctrl_held  (i_ctrl_held),
            .i_shift_held (i_shift_held),
            .o_hit        (hits[g])
        );
    end

    hkr_merge u_merge (
        .i_hits   (hits),
        .o_result (merged)
    );

    assign in_accept = i_valid && !r_skid_valid;
    assign out_free  = !r_out_valid || !i_stall;

    // Buffer occupancy and the stored report.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_prev <= new_codes;
            end
            if (out_free) begin
                r_out_valid  <= r_skid_valid || in_accept;
                r_skid_valid <= 1'b0;
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Result payloads.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : merged;
        end else if (in_accept) begin
            r_skid <= merged;
        end
    end

    assign o_stall      = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_char_valid = r_out.char_valid;
    assign o_char_code  = r_out.char_code;

    // The skid register is only used behind a held output.
    `HKR_ASSERT(a_skid_behind_out, r_skid_valid |-> r_out_valid)
    // A result without a new key carries no code.
    `HKR_ASSERT(a_no_key_zero, (o_valid && !o_char_valid) |-> (o_char_code == 8'h00))
    // A report taken into an empty buffer path shows up next cycle.
    `HKR_ASSERT(a_accept_shows, (in_accept && out_free) |=> o_valid)
    // Reset leaves both sides idle.
    `HKR_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!o_valid && !o_stall))

endmodule

// File: rtl/hkr_lane.sv
// ----------------------------------------------------------------------------
// hkr_lane
// One slot of the report: newness test and translation of its keycode.
// ----------------------------------------------------------------------------
module hkr_lane (
    input  hkr_pkg::t_code     i_code,
    input  hkr_pkg::t_code_vec i_compare,
    input  logic               i_ctrl_held,
    input  logic               i_shift_held,
    output hkr_pkg::t_lane_hit o_hit
);
    import hkr_pkg::*;

    logic  match_any;
    t_code shifted_char;
    t_code chosen_char;
    t_code ctrl_char;
    t_code plain_char;

    // The key is new only if no entry of the comparison set holds it.
    always_comb begin
        match_any = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if (i_compare[j] == i_code) begin
                match_any = 1'b1;
            end
        end
    end

    // With control held, ten letters become control codes; other keys give zero.
    always_comb begin
        shifted_char = lookup(i_code, 1'b1);
        case (shifted_char)
            CHR_A, CHR_B, CHR_C, CHR_D, CHR_E, CHR_F,
            CHR_K, CHR_N, CHR_P, CHR_U: ctrl_char = shifted_char - CTL_OFFSET;
            default:                    ctrl_char = 8'h00;
        endcase
    end

    // Without control, the cursor keys map to editing control codes.
    always_comb begin
        chosen_char = lookup(i_code, i_shift_held);
        case (chosen_char)
            ARROW_LEFT:  plain_char = CTL_B;
            ARROW_RIGHT: plain_char = CTL_F;
            ARROW_DOWN:  plain_char = CTL_N;
            ARROW_UP:    plain_char = CTL_P;
            default:     plain_char = chosen_char;
        endcase
    end

    assign o_hit.fresh     = (i_code != 8'h00) && !match_any;
    assign o_hit.char_code = i_ctrl_held ? ctrl_char : plain_char;

endmodule

// File: rtl/hkr_merge.sv
// ----------------------------------------------------------------------------
// hkr_merge
// Combines the lanes: the highest slot holding a new key gives the result.
// ----------------------------------------------------------------------------
module hkr_merge (
    input  hkr_pkg::t_hit_vec i_hits,
    output hkr_pkg::t_result  o_result
);
    import hkr_pkg::*;

    // Later slots override earlier ones.
    always_comb begin
        o_result = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (i_hits[i].fresh) begin
                o_result.char_valid = 1'b1;
                o_result.char_code  = i_hits[i].char_code;
            end
        end
    end

endmodule
